@@ design/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants, codes and controller/datapath interface types for the
// priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int DEPTH       = 256;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 4;
  localparam int PRIO_N      = 8;
  localparam int LIST_W      = $clog2(PRIO_N);
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 9;
  localparam int IN_FIELDS_W = ID_W + PRIO_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - IN_FIELDS_W;
  localparam int OUT_FIELDS_W = STATUS_W + ID_W + PRIO_W + OCC_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIO_N);

  typedef enum logic {
    OP_ENQ  = 1'b0,
    OP_DISP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ALLOC,
    S_ENQ,
    S_DEQ
  } state_t;

  typedef struct packed {
    logic latch;
    logic fresh_take;
    logic alloc_rd;
    logic alloc_take;
    logic enq_commit;
    logic deq_rd;
    logic deq_commit;
    logic err_commit;
  } cmd_t;

  typedef struct packed {
    logic is_disp;
    logic bad_prio;
    logic full;
    logic empty;
    logic fresh_avail;
    logic out_free;
  } sts_t;

endpackage

@@ design/priority_ready_queue_top.sv @@
// ----------------------------------------------------------------------------
// priority_ready_queue_top
// Sequence: a refused item commits from S_EVAL, an enqueue passes S_EVAL and
// S_ENQ (with S_ALLOC between when it reuses a slot from the free list), and a
// dispatch passes S_EVAL and S_DEQ; slot and link memory reads are registered.
// One item at a time; the next item is accepted while a result waits.
// Reset: synchronous, active low; clears counters and control, memories hold.
// ----------------------------------------------------------------------------
module priority_ready_queue_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // task_id [7:0], priority_req [11:8], zero fill above
  input  logic [prq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op [0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status [1:0], out_task_id [9:2], out_priority [13:10], occupancy [22:14],
  // zero fill above
  output logic [prq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  prq_pkg::cmd_t                  cmd;
  prq_pkg::sts_t                  sts;
  logic [prq_pkg::STATUS_W-1:0]   out_status;
  logic [prq_pkg::ID_W-1:0]       out_task_id;
  logic [prq_pkg::PRIO_W-1:0]     out_priority;
  logic [prq_pkg::OCC_W-1:0]      out_occupancy;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_tuser),
    .in_task_id      (in_tdata[prq_pkg::ID_W-1:0]),
    .in_priority_req (in_tdata[prq_pkg::IN_FIELDS_W-1:prq_pkg::ID_W]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (out_status),
    .out_task_id     (out_task_id),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

  assign out_tdata = {{prq_pkg::OUT_PAD_W{1'b0}}, out_occupancy, out_priority,
                      out_task_id, out_status};

endmodule

@@ design/prq_ctrl.sv @@
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer for one queue item: evaluate, allocate a slot or read the head
// unless the item is refused, then commit the result into the output register.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  prq_pkg::sts_t  sts,
  output prq_pkg::cmd_t  cmd
);

  prq_pkg::state_t state_r;
  prq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      prq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = prq_pkg::S_EVAL;
        end
      end
      prq_pkg::S_EVAL: begin
        if (sts.is_disp) begin
          if (sts.empty) begin
            if (sts.out_free) begin
              cmd.err_commit = 1'b1;
              state_nxt      = prq_pkg::S_IDLE;
            end
          end else begin
            cmd.deq_rd = 1'b1;
            state_nxt  = prq_pkg::S_DEQ;
          end
        end else if (sts.bad_prio || sts.full) begin
          if (sts.out_free) begin
            cmd.err_commit = 1'b1;
            state_nxt      = prq_pkg::S_IDLE;
          end
        end else if (sts.fresh_avail) begin
          cmd.fresh_take = 1'b1;
          state_nxt      = prq_pkg::S_ENQ;
        end else begin
          cmd.alloc_rd = 1'b1;
          state_nxt    = prq_pkg::S_ALLOC;
        end
      end
      prq_pkg::S_ALLOC: begin
        cmd.alloc_take = 1'b1;
        state_nxt      = prq_pkg::S_ENQ;
      end
      prq_pkg::S_ENQ: begin
        if (sts.out_free) begin
          cmd.enq_commit = 1'b1;
          state_nxt      = prq_pkg::S_IDLE;
        end
      end
      prq_pkg::S_DEQ: begin
        if (sts.out_free) begin
          cmd.deq_commit = 1'b1;
          state_nxt      = prq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = prq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/prq_datapath.sv @@
// ----------------------------------------------------------------------------
// prq_datapath
// One linked list per priority over a shared slot memory, a free list threaded
// through the link memory, per-list counters and the output register.
// ----------------------------------------------------------------------------
module prq_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prq_pkg::cmd_t                 cmd,
  output prq_pkg::sts_t                 sts,
  input  logic                          in_op,
  input  logic [prq_pkg::ID_W-1:0]      in_task_id,
  input  logic [prq_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [prq_pkg::STATUS_W-1:0]  out_status,
  output logic [prq_pkg::ID_W-1:0]      out_task_id,
  output logic [prq_pkg::PRIO_W-1:0]    out_priority,
  output logic [prq_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int SLOT_W = prq_pkg::SLOT_W;
  localparam int CNT_W  = prq_pkg::CNT_W;
  localparam int LIST_W = prq_pkg::LIST_W;

  prq_pkg::op_t               op_r;
  logic [prq_pkg::ID_W-1:0]   id_r;
  logic [prq_pkg::PRIO_W-1:0] prio_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [LIST_W-1:0]          sel_r;
  logic [SLOT_W-1:0]          free_head_r;
  logic [SLOT_W-1:0]          head_r [prq_pkg::PRIO_N];
  logic [SLOT_W-1:0]          tail_r [prq_pkg::PRIO_N];
  logic [CNT_W-1:0]           lcnt_r [prq_pkg::PRIO_N];
  logic [CNT_W-1:0]           entry_cnt_r;
  logic [CNT_W-1:0]           fresh_cnt_r;
  logic                       out_valid_r;
  prq_pkg::status_t           out_status_r;
  logic [prq_pkg::ID_W-1:0]   out_id_r;
  logic [prq_pkg::PRIO_W-1:0] out_prio_r;
  logic [prq_pkg::OCC_W-1:0]  out_occ_r;

  logic [prq_pkg::ID_W-1:0]   task_mem [prq_pkg::DEPTH];
  logic [SLOT_W-1:0]          next_mem [prq_pkg::DEPTH];
  logic [prq_pkg::ID_W-1:0]   task_rd_r;
  logic [SLOT_W-1:0]          next_rd_r;

  logic [prq_pkg::PRIO_N-1:0] nonempty;
  logic [LIST_W-1:0]          low_idx;
  logic [LIST_W-1:0]          list_idx;
  logic [SLOT_W-1:0]          head_low;
  logic [SLOT_W-1:0]          tail_sel;
  logic                       next_re;
  logic [SLOT_W-1:0]          next_ra;
  logic                       next_we;
  logic [SLOT_W-1:0]          next_wa;
  logic [SLOT_W-1:0]          next_wd;
  logic                       out_free;
  prq_pkg::status_t           err_status;

  always_comb begin
    low_idx = '0;
    for (int k = prq_pkg::PRIO_N - 1; k >= 0; k--) begin
      nonempty[k] = (lcnt_r[k] != '0);
      if (nonempty[k]) begin
        low_idx = LIST_W'(k);
      end
    end
  end

  assign list_idx = LIST_W'(prio_r - prq_pkg::PRIO_MIN);
  assign head_low = head_r[low_idx];
  assign tail_sel = tail_r[list_idx];
  assign out_free = !out_valid_r || out_tready;

  assign sts.is_disp     = (op_r == prq_pkg::OP_DISP);
  assign sts.bad_prio    = (prio_r < prq_pkg::PRIO_MIN) || (prio_r > prq_pkg::PRIO_MAX);
  assign sts.full        = (entry_cnt_r == CNT_W'(prq_pkg::DEPTH));
  assign sts.empty       = (entry_cnt_r == '0);
  assign sts.fresh_avail = (fresh_cnt_r != CNT_W'(prq_pkg::DEPTH));
  assign sts.out_free    = out_free;

  always_comb begin
    priority if (op_r == prq_pkg::OP_DISP) begin
      err_status = prq_pkg::ST_EMPTY;
    end else if (sts.bad_prio) begin
      err_status = prq_pkg::ST_BAD_PRIO;
    end else begin
      err_status = prq_pkg::ST_FULL;
    end
  end

  assign next_re = cmd.alloc_rd || cmd.deq_rd;
  assign next_ra = cmd.deq_rd ? head_low : free_head_r;
  assign next_we = (cmd.enq_commit && nonempty[list_idx]) || cmd.deq_commit;
  assign next_wa = cmd.deq_commit ? slot_r : tail_sel;
  assign next_wd = cmd.deq_commit ? free_head_r : slot_r;

  always_ff @(posedge clk) begin
    if (cmd.enq_commit) begin
      task_mem[slot_r] <= id_r;
    end
    if (cmd.deq_rd) begin
      task_rd_r <= task_mem[head_low];
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (next_re) begin
      next_rd_r <= next_mem[next_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= prq_pkg::op_t'(in_op);
      id_r   <= in_task_id;
      prio_r <= in_priority_req;
    end
    if (cmd.fresh_take) begin
      slot_r <= fresh_cnt_r[SLOT_W-1:0];
    end
    if (cmd.alloc_take) begin
      slot_r      <= free_head_r;
      free_head_r <= next_rd_r;
    end
    if (cmd.deq_rd) begin
      slot_r <= head_low;
      sel_r  <= low_idx;
    end
    if (cmd.deq_commit) begin
      free_head_r <= slot_r;
    end
    for (int k = 0; k < prq_pkg::PRIO_N; k++) begin
      if (cmd.enq_commit && (list_idx == LIST_W'(k))) begin
        tail_r[k] <= slot_r;
        if (!nonempty[k]) begin
          head_r[k] <= slot_r;
        end
      end
      if (cmd.deq_commit && (sel_r == LIST_W'(k))) begin
        head_r[k] <= next_rd_r;
      end
    end
    if (cmd.err_commit) begin
      out_status_r <= err_status;
      out_id_r     <= '0;
      out_prio_r   <= '0;
      out_occ_r    <= prq_pkg::OCC_W'(entry_cnt_r);
    end
    if (cmd.enq_commit) begin
      out_status_r <= prq_pkg::ST_OK;
      out_id_r     <= '0;
      out_prio_r   <= '0;
      out_occ_r    <= prq_pkg::OCC_W'(entry_cnt_r + CNT_W'(1));
    end
    if (cmd.deq_commit) begin
      out_status_r <= prq_pkg::ST_OK;
      out_id_r     <= task_rd_r;
      out_prio_r   <= prq_pkg::PRIO_W'(sel_r) + prq_pkg::PRIO_MIN;
      out_occ_r    <= prq_pkg::OCC_W'(entry_cnt_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt_r <= '0;
      fresh_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < prq_pkg::PRIO_N; k++) begin
        lcnt_r[k] <= '0;
      end
    end else begin
      if (cmd.fresh_take) begin
        fresh_cnt_r <= fresh_cnt_r + CNT_W'(1);
      end
      if (cmd.enq_commit) begin
        entry_cnt_r <= entry_cnt_r + CNT_W'(1);
      end else if (cmd.deq_commit) begin
        entry_cnt_r <= entry_cnt_r - CNT_W'(1);
      end
      for (int k = 0; k < prq_pkg::PRIO_N; k++) begin
        if (cmd.enq_commit && (list_idx == LIST_W'(k))) begin
          lcnt_r[k] <= lcnt_r[k] + CNT_W'(1);
        end else if (cmd.deq_commit && (sel_r == LIST_W'(k))) begin
          lcnt_r[k] <= lcnt_r[k] - CNT_W'(1);
        end
      end
      if (cmd.err_commit || cmd.enq_commit || cmd.deq_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_task_id   = out_id_r;
  assign out_priority  = out_prio_r;
  assign out_occupancy = out_occ_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= CNT_W'(prq_pkg::DEPTH) && fresh_cnt_r <= CNT_W'(prq_pkg::DEPTH))
    else $error("queue counters exceed depth");
  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_commit |=> entry_cnt_r == $past(entry_cnt_r) + CNT_W'(1))
    else $error("enqueue did not grow occupancy");
  a_deq_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_commit |=> entry_cnt_r == $past(entry_cnt_r) - CNT_W'(1))
    else $error("dispatch did not shrink occupancy");
  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_rd |-> entry_cnt_r != '0 && nonempty != '0)
    else $error("head read from an empty queue");
`endif

endmodule

@@ tb/priority_ready_queue_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_ready_queue_top_tb
// Self-checking bench for the priority ready queue. A driver streams enqueue
// and dispatch requests from a request queue and updates a shadow copy of the
// sorted queue on every accepted transfer. A monitor checks each result
// transfer field by field against the oldest predicted result. Both sides
// idle and stall at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module priority_ready_queue_top_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int SHOWN_MAX  = 10;

  typedef struct {
    prq_pkg::op_t                  op;
    logic [prq_pkg::ID_W-1:0]      id;
    logic [prq_pkg::PRIO_W-1:0]    pr;
  } task_req_t;

  typedef struct {
    prq_pkg::status_t              st;
    logic [prq_pkg::ID_W-1:0]      id;
    logic [prq_pkg::PRIO_W-1:0]    pr;
    logic [prq_pkg::OCC_W-1:0]     occ;
  } sched_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  // task_id [7:0], priority_req [11:8], zero fill above
  logic [prq_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  // op [0]
  logic                               in_tuser = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  // status [1:0], out_task_id [9:2], out_priority [13:10], occupancy [22:14]
  logic [prq_pkg::OUT_TDATA_W-1:0]    out_tdata;

  task_req_t     task_requests[$];
  sched_result_t pending_results[$];

  logic [prq_pkg::PRIO_W-1:0] shadow_pri [prq_pkg::DEPTH];
  logic [prq_pkg::ID_W-1:0]   shadow_id  [prq_pkg::DEPTH];
  int                         shadow_count = 0;

  int gen_occ = 0;
  int err_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int steady_left = 0;
  bit steady = 1'b0;

  priority_ready_queue_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [prq_pkg::PRIO_W-1:0] rand_prio(int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) begin
      if ($urandom_range(0, 1) == 0) return '0;
      return prq_pkg::PRIO_W'($urandom_range(prq_pkg::PRIO_N + 1, 15));
    end
    return prq_pkg::PRIO_W'($urandom_range(1, prq_pkg::PRIO_N));
  endfunction

  task automatic add_item(input prq_pkg::op_t op, input logic [prq_pkg::ID_W-1:0] id,
                          input logic [prq_pkg::PRIO_W-1:0] pr);
    task_req_t t;
    t.op = op;
    t.id = id;
    t.pr = pr;
    task_requests.push_back(t);
    if (op == prq_pkg::OP_ENQ) begin
      if (pr >= prq_pkg::PRIO_MIN && pr <= prq_pkg::PRIO_MAX &&
          gen_occ < prq_pkg::DEPTH) gen_occ++;
    end else if (gen_occ > 0) begin
      gen_occ--;
    end
  endtask

  task automatic add_mix(input int count, input int enq_pct);
    int i;
    for (i = 0; i < count; i++) begin
      add_item(($urandom_range(0, 99) < enq_pct) ? prq_pkg::OP_ENQ : prq_pkg::OP_DISP,
               prq_pkg::ID_W'($urandom_range(0, 255)), rand_prio(10));
    end
  endtask

  // Insert behind all entries of equal or better priority, or pop the head.
  task automatic queue_step(input prq_pkg::op_t op, input logic [prq_pkg::ID_W-1:0] id,
                            input logic [prq_pkg::PRIO_W-1:0] pr);
    sched_result_t r;
    int pos;
    int k;
    r.st = prq_pkg::ST_OK;
    r.id = '0;
    r.pr = '0;
    if (op == prq_pkg::OP_ENQ) begin
      if (pr < prq_pkg::PRIO_MIN || pr > prq_pkg::PRIO_MAX) begin
        r.st = prq_pkg::ST_BAD_PRIO;
      end else if (shadow_count >= prq_pkg::DEPTH) begin
        r.st = prq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_pri[pos] <= pr) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_pri[k] = shadow_pri[k-1];
          shadow_id[k]  = shadow_id[k-1];
        end
        shadow_pri[pos] = pr;
        shadow_id[pos]  = id;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.st = prq_pkg::ST_EMPTY;
    end else begin
      r.id = shadow_id[0];
      r.pr = shadow_pri[0];
      for (k = 0; k + 1 < shadow_count; k++) begin
        shadow_pri[k] = shadow_pri[k+1];
        shadow_id[k]  = shadow_id[k+1];
      end
      shadow_count--;
    end
    r.occ = prq_pkg::OCC_W'(shadow_count);
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (steady_left > 0) begin
      steady_left <= steady_left - 1;
    end else begin
      steady      <= ($urandom_range(0, 2) == 0);
      steady_left <= $urandom_range(20, 200);
    end
  end

  // driver
  always @(posedge clk) begin
    task_req_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        queue_step(prq_pkg::op_t'(in_tuser), in_tdata[prq_pkg::ID_W-1:0],
                   in_tdata[prq_pkg::ID_W +: prq_pkg::PRIO_W]);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (task_requests.size() != 0) begin
          t = task_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= t.op;
          in_tdata  <= {{prq_pkg::IN_PAD_W{1'b0}}, t.pr, t.id};
          gap_left  <= steady ? 0 : gap_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_result_t exp_r;
    sched_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.st  = prq_pkg::status_t'(out_tdata[prq_pkg::STATUS_W-1:0]);
        got.id  = out_tdata[prq_pkg::STATUS_W +: prq_pkg::ID_W];
        got.pr  = out_tdata[prq_pkg::STATUS_W + prq_pkg::ID_W +: prq_pkg::PRIO_W];
        got.occ = out_tdata[prq_pkg::STATUS_W + prq_pkg::ID_W + prq_pkg::PRIO_W +:
                            prq_pkg::OCC_W];
        if (pending_results.size() == 0) begin
          err_count++;
          mismatch_count++;
          if (mismatch_count <= SHOWN_MAX) begin
            $display("unexpected result: status %0d id %0d prio %0d occ %0d",
                     got.st, got.id, got.pr, got.occ);
          end
        end else begin
          exp_r = pending_results.pop_front();
          if (got.st !== exp_r.st || got.id !== exp_r.id ||
              got.pr !== exp_r.pr || got.occ !== exp_r.occ) begin
            err_count++;
            mismatch_count++;
            if (mismatch_count <= SHOWN_MAX) begin
              $display("mismatch: exp st %0d id %0d pr %0d occ %0d, got %0d %0d %0d %0d",
                       exp_r.st, exp_r.id, exp_r.pr, exp_r.occ,
                       got.st, got.id, got.pr, got.occ);
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left <= gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("priority_ready_queue_top_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int i;
    // directed: empty pop, out-of-range priorities, ties at both ends
    add_item(prq_pkg::OP_DISP, 8'hA5, 4'hF);
    add_item(prq_pkg::OP_ENQ, 8'h12, 4'd0);
    add_item(prq_pkg::OP_ENQ, 8'h34, 4'd9);
    add_item(prq_pkg::OP_ENQ, 8'hFF, 4'd15);
    add_item(prq_pkg::OP_ENQ, 8'hFF, prq_pkg::PRIO_MAX);
    add_item(prq_pkg::OP_ENQ, 8'h00, prq_pkg::PRIO_MIN);
    add_item(prq_pkg::OP_ENQ, 8'h11, 4'd4);
    add_item(prq_pkg::OP_ENQ, 8'h22, 4'd4);
    add_item(prq_pkg::OP_ENQ, 8'h33, prq_pkg::PRIO_MAX);
    add_item(prq_pkg::OP_ENQ, 8'h44, prq_pkg::PRIO_MIN);
    add_item(prq_pkg::OP_ENQ, 8'h55, 4'd3);
    for (i = 0; i < 8; i++) begin
      add_item(prq_pkg::OP_DISP, prq_pkg::ID_W'($urandom_range(0, 255)), 4'h0);
    end
    add_item(prq_pkg::OP_DISP, 8'h00, 4'h8);

    add_mix(60, 55);
    // fill to capacity, then push against the full queue
    while (gen_occ < prq_pkg::DEPTH) begin
      add_item(prq_pkg::OP_ENQ, prq_pkg::ID_W'($urandom_range(0, 255)), rand_prio(5));
    end
    for (i = 0; i < 3; i++) begin
      add_item(prq_pkg::OP_ENQ, prq_pkg::ID_W'($urandom_range(0, 255)), rand_prio(0));
    end
    add_item(prq_pkg::OP_ENQ, 8'h5A, 4'd0);
    add_item(prq_pkg::OP_ENQ, 8'hA5, 4'd13);
    add_item(prq_pkg::OP_ENQ, 8'hC3, prq_pkg::PRIO_MIN);
    // recycle freed slots
    add_mix(50, 35);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (task_requests.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("priority_ready_queue_top_tb: clean");
    end else begin
      $display("priority_ready_queue_top_tb: errors");
    end
    $finish;
  end

endmodule
